>>> design/ctb_pkg.sv
// Shared codes for the cursor text buffer: operation and status encodings.
// No dependencies; imported by cursor_text_buffer.
package ctb_pkg;

   typedef logic [2:0] op_code_type;
   typedef logic [1:0] status_type;

   localparam op_code_type OP_FORWARD = 3'd0;
   localparam op_code_type OP_BACK    = 3'd1;
   localparam op_code_type OP_START   = 3'd2;
   localparam op_code_type OP_END     = 3'd3;
   localparam op_code_type OP_INSERT  = 3'd4;
   localparam op_code_type OP_DELETE  = 3'd5;
   localparam op_code_type OP_READ    = 3'd6;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_FULL      = 2'd1;
   localparam status_type STATUS_BAD_INDEX = 2'd2;

endpackage

>>> design/cursor_text_buffer.sv
// Cursor text buffer top level: byte store in a one-port-write, one-port-read
// synchronous RAM, cursor and length counters, shift sequencer. Uses ctb_pkg.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     req_tdata  op, char_in, read_index
//   rsp_     out  rsp_tvalid/tready     rsp_tdata  cursor_pos, text_length,
//                                                  char_out, status
//
// Cursor moves and refused ops go from idle to the result state, a read through a
// read-wait state. Insert and delete shift bytes in the RAM, one byte per cycle,
// each read and then written back from the registered read data.
// A new request is taken only while the sequencer is idle; a finished response
// may still wait in the output register. Reset clears cursor, length and the
// handshake state; the RAM contents are not cleared.
module cursor_text_buffer
   import ctb_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [2:0] op, [10:3] char_in, [18:11] read_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [8:0] cursor_pos, [17:9] text_length,
                                    // [25:18] char_out, [27:26] status
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_WAIT,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_PUT,
      S_RESULT
   } state_type;

   state_type    state_ff;
   logic [CW-1:0] cursor_ff;
   logic [CW-1:0] length_ff;
   logic [AW-1:0] ptr_ff;
   logic [7:0]   char_ff;
   logic [7:0]   res_char_ff;
   status_type   res_status_ff;
   logic         rsp_tvalid_ff;
   logic [8:0]   rsp_cursor_ff;
   logic [8:0]   rsp_length_ff;
   logic [7:0]   rsp_char_ff;
   status_type   rsp_status_ff;

   // byte store
   logic [7:0]   mem [CAPACITY];
   logic [7:0]   mem_rdata_ff;
   logic [AW-1:0] mem_raddr;
   logic [AW-1:0] mem_waddr;
   logic [7:0]   mem_wdata;
   logic         mem_we;

   op_code_type  req_op;
   logic [7:0]   req_char;
   logic [7:0]   req_idx;
   logic         req_fire;
   logic         rsp_free;

   logic [AW-1:0] cur_a;
   logic [AW-1:0] len_a;
   logic [AW-1:0] len_m1_a;
   logic [AW-1:0] cur_p1_a;
   logic [AW+7:0] idx_wide;
   logic [AW-1:0] idx_a;
   logic [CW+7:0] idx_cmp;
   logic [CW+7:0] len_cmp;
   logic         idx_bad;
   logic [CW+8:0] cur_ext;
   logic [CW+8:0] len_ext;

   assign req_op   = req_tdata[2:0];
   assign req_char = req_tdata[10:3];
   assign req_idx  = req_tdata[18:11];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   assign cur_a    = cursor_ff[AW-1:0];
   assign len_a    = length_ff[AW-1:0];
   assign len_m1_a = len_a - AW'(1);
   assign cur_p1_a = cur_a + AW'(1);
   assign idx_wide = {{AW{1'b0}}, req_idx};
   assign idx_a    = idx_wide[AW-1:0];
   assign idx_cmp  = {{CW{1'b0}}, req_idx};
   assign len_cmp  = {8'b0, length_ff};
   assign idx_bad  = (idx_cmp >= len_cmp);
   assign cur_ext  = {9'b0, cursor_ff};
   assign len_ext  = {9'b0, length_ff};

   // RAM address and write selection
   always_comb begin
      mem_raddr = ptr_ff - AW'(1);
      mem_waddr = cur_a;
      mem_wdata = char_ff;
      mem_we    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_op == OP_INSERT) begin
               mem_raddr = len_m1_a;
            end else if (req_op == OP_DELETE) begin
               mem_raddr = cur_p1_a;
            end else begin
               mem_raddr = idx_a;
            end
         end
         S_SHIFT_UP: begin
            mem_raddr = ptr_ff - AW'(1);
            mem_waddr = ptr_ff + AW'(1);
            mem_wdata = mem_rdata_ff;
            mem_we    = 1'b1;
         end
         S_SHIFT_DN: begin
            mem_raddr = ptr_ff + AW'(1);
            mem_waddr = ptr_ff - AW'(1);
            mem_wdata = mem_rdata_ff;
            mem_we    = 1'b1;
         end
         S_PUT: begin
            mem_waddr = cur_a;
            mem_wdata = char_ff;
            mem_we    = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_ff     <= '0;
         length_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // in S_RESULT the response register is reloaded below instead
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_RESULT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  char_ff       <= req_char;
                  res_char_ff   <= 8'd0;
                  res_status_ff <= STATUS_OK;
                  state_ff      <= S_RESULT;
                  case (req_op)
                     OP_FORWARD: begin
                        if (cursor_ff < length_ff) begin
                           cursor_ff <= cursor_ff + CW'(1);
                        end
                     end
                     OP_BACK: begin
                        if (cursor_ff != '0) begin
                           cursor_ff <= cursor_ff - CW'(1);
                        end
                     end
                     OP_START: begin
                        cursor_ff <= '0;
                     end
                     OP_END: begin
                        cursor_ff <= length_ff;
                     end
                     OP_INSERT: begin
                        if (length_ff >= CW'(CAPACITY)) begin
                           res_status_ff <= STATUS_FULL;
                        end else if (length_ff > cursor_ff) begin
                           ptr_ff   <= len_m1_a;
                           state_ff <= S_SHIFT_UP;
                        end else begin
                           state_ff <= S_PUT;
                        end
                     end
                     OP_DELETE: begin
                        if (cursor_ff < length_ff) begin
                           if (cursor_ff + CW'(1) < length_ff) begin
                              ptr_ff   <= cur_p1_a;
                              state_ff <= S_SHIFT_DN;
                           end else begin
                              length_ff <= length_ff - CW'(1);
                           end
                        end
                     end
                     OP_READ: begin
                        if (idx_bad) begin
                           res_status_ff <= STATUS_BAD_INDEX;
                        end else begin
                           state_ff <= S_READ_WAIT;
                        end
                     end
                     default: begin
                        res_status_ff <= STATUS_OK;
                     end
                  endcase
               end
            end
            S_READ_WAIT: begin
               res_char_ff <= mem_rdata_ff;
               state_ff    <= S_RESULT;
            end
            S_SHIFT_UP: begin
               // ptr_ff is the source byte whose data sits in mem_rdata_ff
               if (ptr_ff == cur_a) begin
                  state_ff <= S_PUT;
               end else begin
                  ptr_ff <= ptr_ff - AW'(1);
               end
            end
            S_SHIFT_DN: begin
               if (ptr_ff == len_m1_a) begin
                  length_ff <= length_ff - CW'(1);
                  state_ff  <= S_RESULT;
               end else begin
                  ptr_ff <= ptr_ff + AW'(1);
               end
            end
            S_PUT: begin
               length_ff <= length_ff + CW'(1);
               cursor_ff <= cursor_ff + CW'(1);
               state_ff  <= S_RESULT;
            end
            S_RESULT: begin
               if (rsp_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_cursor_ff <= cur_ext[8:0];
                  rsp_length_ff <= len_ext[8:0];
                  rsp_char_ff   <= res_char_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0, rsp_status_ff, rsp_char_ff, rsp_length_ff, rsp_cursor_ff};

`ifndef ASSERT_OFF
   a_cursor_in_text: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= length_ff)
      else $error("cursor beyond text length");

   a_length_in_range: assert property (@(posedge clock) disable iff (reset)
      length_ff <= CW'(CAPACITY))
      else $error("text length beyond capacity");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("store written while sequencer idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("request accepted without starting work");
`endif

endmodule

>>> sim/cursor_text_buffer_test.sv
// Self-checking bench for cursor_text_buffer: random and directed edit requests
// checked against a behavioral mirror of the text, cursor and length.
// Depends on ctb_pkg and cursor_text_buffer from the design folder.
module cursor_text_buffer_test
   import ctb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = 256;
   localparam int RANDOM_ITEMS  = 1900;
   localparam int DRAIN_CYCLES  = 300;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int MAX_REPORTS   = 10;
   localparam op_code_type OP_UNUSED = 3'd7;

   typedef struct packed {
      op_code_type op;
      logic [7:0]  ch;
      logic [7:0]  read_at;
   } edit_request_type;

   typedef struct packed {
      logic [8:0] cursor;
      logic [8:0] length;
      logic [7:0] ch;
      status_type status;
   } edit_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [2:0] op, [10:3] char_in, [18:11] read_index
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [8:0] cursor_pos, [17:9] text_length,
                                   // [25:18] char_out, [27:26] status

   // mirror of the text held by the block
   logic [7:0] text_mirror [0:CAPACITY-1];
   int         mirror_len    = 0;
   int         mirror_cursor = 0;

   edit_request_type pending_requests [$];
   edit_result_type  expected_results [$];
   edit_request_type request_live;
   int request_total  = 0;
   int requests_taken = 0;
   int random_count   = 0;
   int error_count    = 0;
   int cycle_count    = 0;
   int req_hold       = 0;
   int req_calm       = 0;
   int rsp_hold       = 0;
   int rsp_calm       = 0;

   cursor_text_buffer #(.CAPACITY(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one edit to the mirror and returns the response it should produce.
   function automatic edit_result_type apply_edit(edit_request_type r);
      edit_result_type res;
      int i;
      res = '0;
      res.status = STATUS_OK;
      case (r.op)
         OP_FORWARD: begin
            if (mirror_cursor < mirror_len) mirror_cursor++;
         end
         OP_BACK: begin
            if (mirror_cursor > 0) mirror_cursor--;
         end
         OP_START: begin
            mirror_cursor = 0;
         end
         OP_END: begin
            mirror_cursor = mirror_len;
         end
         OP_INSERT: begin
            if (mirror_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = mirror_len; i > mirror_cursor; i--)
                  text_mirror[i] = text_mirror[i-1];
               text_mirror[mirror_cursor] = r.ch;
               mirror_len++;
               mirror_cursor++;
            end
         end
         OP_DELETE: begin
            if (mirror_cursor < mirror_len) begin
               for (i = mirror_cursor; i + 1 < mirror_len; i++)
                  text_mirror[i] = text_mirror[i+1];
               mirror_len--;
            end
         end
         OP_READ: begin
            if (int'(r.read_at) >= mirror_len)
               res.status = STATUS_BAD_INDEX;
            else
               res.ch = text_mirror[r.read_at];
         end
         default: begin
         end
      endcase
      res.cursor = mirror_cursor[8:0];
      res.length = mirror_len[8:0];
      return res;
   endfunction

   // Per-item wait, with occasional stretches of back-to-back traffic.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   task automatic note_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endtask

   task automatic queue_request(op_code_type op, logic [7:0] ch, logic [7:0] read_at);
      edit_request_type r;
      r.op = op;
      r.ch = ch;
      r.read_at = read_at;
      pending_requests.push_back(r);
   endtask

   task automatic queue_random(op_code_type op);
      queue_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_count++;
   endtask

   // Phases: grow to full, read sweep, mixed noise, shrink, mixed noise.
   task automatic build_random_requests();
      int i, pick;
      op_code_type op;
      while (random_count < RANDOM_ITEMS) begin
         for (i = 0; i < 290 && random_count < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 92) begin
               op = OP_INSERT;
            end else begin
               case ($urandom_range(0, 3))
                  0: op = OP_FORWARD;
                  1: op = OP_BACK;
                  2: op = OP_START;
                  default: op = OP_END;
               endcase
            end
            queue_random(op);
         end
         for (i = 0; i < 50 && random_count < RANDOM_ITEMS; i++)
            queue_random(OP_READ);
         for (i = 0; i < 80 && random_count < RANDOM_ITEMS; i++)
            queue_random(op_code_type'($urandom_range(0, OP_UNUSED)));
         for (i = 0; i < 260 && random_count < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      op = OP_DELETE;
            else if (pick < 75) op = OP_START;
            else if (pick < 85) op = OP_BACK;
            else if (pick < 95) op = OP_FORWARD;
            else                op = OP_END;
            queue_random(op);
         end
         for (i = 0; i < 50 && random_count < RANDOM_ITEMS; i++)
            queue_random(op_code_type'($urandom_range(0, OP_UNUSED)));
      end
   endtask

   always @(posedge clock) begin : drive_requests
      edit_request_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_edit(request_live));
            requests_taken <= requests_taken + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (req_hold > 0) begin
               req_hold   <= req_hold - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               next_req = pending_requests.pop_front();
               request_live <= next_req;
               req_tdata    <= {5'b0, next_req.read_at, next_req.ch, next_req.op};
               req_tvalid   <= 1'b1;
               req_hold     <= draw_wait(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      edit_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cursor = rsp_tdata[8:0];
            got.length = rsp_tdata[17:9];
            got.ch     = rsp_tdata[25:18];
            got.status = rsp_tdata[27:26];
            if (expected_results.size() == 0) begin
               note_error($sformatf("unexpected response: cursor %0d length %0d char %02h status %0d",
                  got.cursor, got.length, got.ch, got.status));
            end else begin
               want = expected_results.pop_front();
               if (got.cursor !== want.cursor || got.length !== want.length ||
                   got.ch !== want.ch || got.status !== want.status)
                  note_error($sformatf({"mismatch: expected cursor %0d length %0d char %02h",
                     " status %0d, got cursor %0d length %0d char %02h status %0d"},
                     want.cursor, want.length, want.ch, want.status,
                     got.cursor, got.length, got.ch, got.status));
            end
            rsp_hold = draw_wait(rsp_calm);
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      // directed: empty-buffer corner cases, both ends of the text, bad reads
      queue_request(OP_FORWARD, 8'h00, 8'h00);
      queue_request(OP_BACK,    8'hFF, 8'hFF);
      queue_request(OP_DELETE,  8'h00, 8'h00);
      queue_request(OP_READ,    8'h00, 8'h00);
      queue_request(OP_UNUSED,  8'hFF, 8'hFF);
      queue_request(OP_INSERT,  8'h00, 8'h00);
      queue_request(OP_INSERT,  8'hFF, 8'hFF);
      queue_request(OP_INSERT,  8'h5A, 8'h00);
      queue_request(OP_START,   8'h00, 8'h00);
      queue_request(OP_INSERT,  8'h81, 8'h00);
      queue_request(OP_READ,    8'h00, 8'h00);
      queue_request(OP_READ,    8'h00, 8'h03);
      queue_request(OP_READ,    8'h00, 8'h04);
      queue_request(OP_READ,    8'h00, 8'hFF);
      queue_request(OP_END,     8'h00, 8'h00);
      queue_request(OP_FORWARD, 8'h00, 8'h00);
      queue_request(OP_BACK,    8'h00, 8'h00);
      queue_request(OP_DELETE,  8'h00, 8'h00);
      queue_request(OP_DELETE,  8'h00, 8'h00);
      queue_request(OP_START,   8'h00, 8'h00);
      queue_request(OP_DELETE,  8'h00, 8'h00);
      queue_request(OP_BACK,    8'h00, 8'h00);
      queue_request(OP_READ,    8'h00, 8'h01);
      build_random_requests();
      request_total = pending_requests.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (requests_taken < request_total) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ctb_pkg.sv
design/cursor_text_buffer.sv
sim/cursor_text_buffer_test.sv
